@@ design/crc32pf_pkg.sv @@
// Shared types, constants and the byte-wide CRC-32 update for the CRC-32 packet framer.
// No dependencies; every design file refers to it by scoped names.
package crc32pf_pkg;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcXorOut = 32'hFFFF_FFFF;

  localparam logic [7:0] LenReset   = 8'd2;
  localparam logic [7:0] StartReset = 8'h01;
  localparam logic [7:0] EndReset   = 8'hFF;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_START  = 2'd1,
    REG_END    = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ROLE_START   = 3'd0,
    ROLE_LENGTH  = 3'd1,
    ROLE_PAYLOAD = 3'd2,
    ROLE_CRC     = 3'd3,
    ROLE_END     = 3'd4
  } role_e;

  // Position of a byte within the burst that one payload byte causes.
  typedef enum logic [2:0] {
    SLOT_START   = 3'd0,
    SLOT_LENGTH  = 3'd1,
    SLOT_PAYLOAD = 3'd2,
    SLOT_CRC0    = 3'd3,
    SLOT_CRC1    = 3'd4,
    SLOT_CRC2    = 3'd5,
    SLOT_CRC3    = 3'd6,
    SLOT_END     = 3'd7
  } slot_e;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic role_e slot_role(input slot_e slot);
    role_e r;
    unique case (slot)
      SLOT_START:   r = ROLE_START;
      SLOT_LENGTH:  r = ROLE_LENGTH;
      SLOT_PAYLOAD: r = ROLE_PAYLOAD;
      SLOT_CRC0,
      SLOT_CRC1,
      SLOT_CRC2,
      SLOT_CRC3:    r = ROLE_CRC;
      SLOT_END:     r = ROLE_END;
      default:      r = ROLE_PAYLOAD;
    endcase
    return r;
  endfunction

endpackage

@@ design/crc32_packet_framer.sv @@
// Top level of the CRC-32 packet framer: configuration registers, CRC state and output burst.
// Depends on crc32pf_pkg.
//
// Each accepted payload byte yields one to eight output transfers: start marker and length
// ahead of the first byte of a frame, the byte itself, and after the last byte the four CRC
// bytes (reflected CRC-32, low byte first) and the end marker. The CRC update for a byte is
// done in the accepting cycle, so a new payload byte is taken in every cycle while each byte
// causes a single transfer and the output is not stalled; a byte that opens or closes a frame
// holds the input until the last of its output transfers (three, six or eight) is taken, as
// the output register emits one byte per cycle when not stalled. The output register is the
// decoupling stage, so the next input transfer is taken in the cycle the burst's last byte leaves.
module crc32_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  byte_role_o,
  output logic        run_last_o
);

  logic [7:0]  len_q, start_q, end_q;
  logic [31:0] crc_q, crc_d;
  logic [7:0]  seen_q, seen_d;

  logic        itm_vld_q, itm_vld_d;
  logic        itm_trl_q;
  logic [7:0]  itm_byte_q, itm_start_q, itm_len_q, itm_end_q;
  logic [31:0] itm_crc_q;
  crc32pf_pkg::slot_e idx_q, idx_d;
  crc32pf_pkg::slot_e last_slot;

  logic        cfg_wr, in_acc, out_acc, burst_done, frame_done;
  logic [31:0] crc_upd;
  logic [7:0]  seen_inc;
  crc32pf_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = crc32pf_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= crc32pf_pkg::LenReset;
      start_q <= crc32pf_pkg::StartReset;
      end_q   <= crc32pf_pkg::EndReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        crc32pf_pkg::REG_LENGTH: len_q   <= pwdata[7:0];
        crc32pf_pkg::REG_START:  start_q <= pwdata[7:0];
        crc32pf_pkg::REG_END:    end_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      crc32pf_pkg::REG_LENGTH: prdata = {24'd0, len_q};
      crc32pf_pkg::REG_START:  prdata = {24'd0, start_q};
      crc32pf_pkg::REG_END:    prdata = {24'd0, end_q};
      default:                 prdata = 32'd0;
    endcase
  end

  assign last_slot  = itm_trl_q ? crc32pf_pkg::SLOT_END : crc32pf_pkg::SLOT_PAYLOAD;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign burst_done = out_acc && (idx_q == last_slot);
  assign in_stall_o = itm_vld_q && !burst_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign crc_upd    = crc32pf_pkg::crc_byte(crc_q, payload_byte_i);
  assign seen_inc   = seen_q + 8'd1;
  assign frame_done = (seen_inc == len_q);

  always_comb begin
    crc_d     = crc_q;
    seen_d    = seen_q;
    itm_vld_d = itm_vld_q;
    idx_d     = idx_q;
    if (in_acc) begin
      crc_d     = frame_done ? crc32pf_pkg::CrcInit : crc_upd;
      seen_d    = frame_done ? 8'd0 : seen_inc;
      itm_vld_d = 1'b1;
      idx_d     = (seen_q == 8'd0) ? crc32pf_pkg::SLOT_START : crc32pf_pkg::SLOT_PAYLOAD;
    end else if (burst_done) begin
      itm_vld_d = 1'b0;
    end else if (out_acc) begin
      idx_d = crc32pf_pkg::slot_e'(idx_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= crc32pf_pkg::CrcInit;
      seen_q    <= 8'd0;
      itm_vld_q <= 1'b0;
      idx_q     <= crc32pf_pkg::SLOT_START;
    end else begin
      crc_q     <= crc_d;
      seen_q    <= seen_d;
      itm_vld_q <= itm_vld_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      itm_trl_q   <= frame_done;
      itm_byte_q  <= payload_byte_i;
      itm_crc_q   <= crc_upd ^ crc32pf_pkg::CrcXorOut;
      itm_start_q <= start_q;
      itm_len_q   <= len_q;
      itm_end_q   <= end_q;
    end
  end

  assign out_valid_o = itm_vld_q;
  assign run_last_o  = (idx_q == last_slot);
  assign byte_role_o = 3'(crc32pf_pkg::slot_role(idx_q));

  always_comb begin
    unique case (idx_q)
      crc32pf_pkg::SLOT_START:   out_byte_o = itm_start_q;
      crc32pf_pkg::SLOT_LENGTH:  out_byte_o = itm_len_q;
      crc32pf_pkg::SLOT_PAYLOAD: out_byte_o = itm_byte_q;
      crc32pf_pkg::SLOT_CRC0:    out_byte_o = itm_crc_q[7:0];
      crc32pf_pkg::SLOT_CRC1:    out_byte_o = itm_crc_q[15:8];
      crc32pf_pkg::SLOT_CRC2:    out_byte_o = itm_crc_q[23:16];
      crc32pf_pkg::SLOT_CRC3:    out_byte_o = itm_crc_q[31:24];
      crc32pf_pkg::SLOT_END:     out_byte_o = itm_end_q;
      default:                   out_byte_o = itm_byte_q;
    endcase
  end

  // Between frames the CRC must sit at its initial value.
  a_crc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q == 8'd0) |-> (crc_q == crc32pf_pkg::CrcInit))
    else $error("CRC not reinitialized at frame boundary");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && run_last_o && !in_acc) |=> !out_valid_o)
    else $error("Output still valid after the last transfer of a burst");

  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (byte_role_o == 3'(crc32pf_pkg::ROLE_START))) |-> !run_last_o)
    else $error("Start marker flagged as last transfer");

  a_header_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (seen_q == 8'd0)) |=> (idx_q == crc32pf_pkg::SLOT_START))
    else $error("Frame opened without a start marker");

  a_hold_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> in_stall_o)
    else $error("Input taken while a burst is still in progress");

endmodule
